>>> hw/rtl/aes_ctr_pkg.sv
// Package: shared types, constants and AES helper functions for the CTR cipher.
package aes_ctr_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumRoundKeys = NumRounds + 1;
  localparam int unsigned RkIdxW = $clog2(NumRoundKeys);
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow = 1'b1;

  typedef enum logic [1:0] {
    ST_EXPAND,
    ST_IDLE,
    ST_ROUND,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic key_start;
    logic key_step;
    logic blk_load;
    logic blk_round;
    logic blk_finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

  localparam logic [7:0] SboxTab [256] = '{
    8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
    8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
    8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
    8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
    8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
    8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
    8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
    8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
    8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
    8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
    8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
    8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
    8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
    8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
    8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
    8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
    8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
    8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
    8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
    8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
    8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
    8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
    8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
    8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
    8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
    8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
    8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
    8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
    8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
    8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
  };

  localparam logic [7:0] RconTab [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
  };

  // byte i of the state sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(logic [127:0] s, int unsigned i);
    get_byte = s[127 - 8 * i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [127:0] sub_shift(logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (c * 4 + r) -: 8] = SboxTab[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, c * 4);
      a1 = get_byte(s, c * 4 + 1);
      a2 = get_byte(s, c * 4 + 2);
      a3 = get_byte(s, c * 4 + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_cols = t;
  endfunction

  function automatic logic [127:0] next_round_key(logic [127:0] k, logic [7:0] rc);
    logic [31:0] t;
    logic [127:0] n;
    t = {SboxTab[k[23:16]] ^ rc, SboxTab[k[15:8]], SboxTab[k[7:0]], SboxTab[k[31:24]]};
    n[127:96] = k[127:96] ^ t;
    n[95:64] = k[95:64] ^ n[127:96];
    n[63:32] = k[63:32] ^ n[95:64];
    n[31:0] = k[31:0] ^ n[63:32];
    next_round_key = n;
  endfunction

endpackage

>>> hw/rtl/aes_ctr_if.sv
// Interfaces: input word, result word and key write channels.
interface aes_ctr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] iv_high;
  logic [63:0] iv_low;
  logic [63:0] text_high;
  logic [63:0] text_low;
  logic [4:0]  byte_count;
  modport source (output valid, mode, iv_high, iv_low, text_high, text_low, byte_count,
                  input ready);
  modport sink (input valid, mode, iv_high, iv_low, text_high, text_low, byte_count,
                output ready);
endinterface

interface aes_ctr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic [4:0]  out_count;
  modport source (output valid, out_high, out_low, out_count, input ready);
  modport sink (input valid, out_high, out_low, out_count, output ready);
endinterface

interface aes_ctr_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/aes_ctr_ram.sv
// Generic RAM with one write port and one registered read port.
module aes_ctr_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/aes_ctr_ctrl.sv
// Controller: sequences key expansion, the rounds of one block and the result.
module aes_ctr_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      key_write,
  input  logic                      in_fire,
  input  aes_ctr_pkg::dp_status_t   status,
  output aes_ctr_pkg::dp_cmd_t      cmd,
  output logic                      in_ready,
  output logic                      cfg_ready,
  output logic [aes_ctr_pkg::RkIdxW-1:0] rk_addr
);
  import aes_ctr_pkg::*;

  ctrl_state_t state, state_next;
  logic [RkIdxW-1:0] step, step_next;
  logic kick;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EXPAND;
      step <= '0;
      kick <= 1'b1;
    end else begin
      state <= state_next;
      step <= step_next;
      kick <= key_write;
    end
  end

  always_comb begin
    state_next = state;
    step_next = step;
    case (state)
      ST_EXPAND: begin
        if (kick) begin
          step_next = '0;
        end else if (step == RkIdxW'(NumRounds)) begin
          state_next = ST_IDLE;
          step_next = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_IDLE: begin
        if (key_write) begin
          state_next = ST_EXPAND;
        end else if (in_fire) begin
          state_next = ST_ROUND;
          step_next = RkIdxW'(1);
        end
      end
      ST_ROUND: begin
        if (step == RkIdxW'(NumRounds)) begin
          state_next = ST_OUT;
          step_next = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_OUT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // round key read address: one ahead of the step that consumes it
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    cfg_ready = 1'b0;
    rk_addr = '0;
    case (state)
      ST_EXPAND: begin
        cmd.key_start = kick;
        cmd.key_step = !kick;
        rk_addr = step;
      end
      ST_IDLE: begin
        cfg_ready = 1'b1;
        // a key write takes priority over a text word in the same cycle
        in_ready = !status.out_full && !key_write;
        cmd.blk_load = in_fire;
        rk_addr = '0;
      end
      ST_ROUND: begin
        cmd.blk_round = 1'b1;
        rk_addr = step;
      end
      ST_OUT: begin
        cmd.blk_finish = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end
endmodule

>>> hw/rtl/aes_ctr_dp.sv
// Datapath: key schedule, round unit, counter and output register.
module aes_ctr_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  aes_ctr_pkg::dp_cmd_t      cmd,
  input  logic [aes_ctr_pkg::RkIdxW-1:0] rk_addr,
  input  logic [63:0]               key_high,
  input  logic [63:0]               key_low,
  input  logic                      mode,
  input  logic [63:0]               iv_high,
  input  logic [63:0]               iv_low,
  input  logic [63:0]               text_high,
  input  logic [63:0]               text_low,
  input  logic [4:0]                byte_count,
  input  logic                      out_take,
  output aes_ctr_pkg::dp_status_t   status,
  output logic [63:0]               out_high,
  output logic [63:0]               out_low,
  output logic [4:0]                out_count
);
  import aes_ctr_pkg::*;

  logic [127:0] key_reg;
  logic [RkIdxW-1:0] key_idx;
  logic [RkIdxW-1:0] rk_waddr;
  logic [127:0] rk_wdata;
  logic rk_we;
  logic [127:0] rk_rdata;
  logic [127:0] state_reg;
  logic [127:0] counter;
  logic [127:0] text_reg;
  logic [4:0] count_reg;
  logic [127:0] round_out;
  logic [127:0] ks;
  logic [127:0] res;
  logic last_round;
  logic out_full;
  logic [RkIdxW-1:0] round_idx;

  assign rk_wdata = cmd.key_start ? {key_high, key_low}
                                  : next_round_key(key_reg, RconTab[key_idx - 1'b1]);
  assign rk_we = cmd.key_start || (cmd.key_step && key_idx != '0);
  assign rk_waddr = cmd.key_start ? '0 : key_idx;

  aes_ctr_ram #(.Width(128), .Depth(NumRoundKeys)) u_rk_ram (
    .clk  (clk),
    .we   (rk_we),
    .waddr(rk_waddr),
    .wdata(rk_wdata),
    .raddr(rk_addr),
    .rdata(rk_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.key_start) begin
      key_reg <= {key_high, key_low};
      key_idx <= RkIdxW'(1);
    end else if (cmd.key_step && key_idx != '0) begin
      key_reg <= rk_wdata;
      key_idx <= (key_idx == RkIdxW'(NumRounds)) ? '0 : key_idx + 1'b1;
    end
  end

  // state holds counter/IV before key add; round key is registered
  assign last_round = (round_idx == RkIdxW'(NumRounds));
  always_comb begin
    if (round_idx == '0) begin
      round_out = state_reg ^ rk_rdata;
    end else if (last_round) begin
      round_out = sub_shift(state_reg) ^ rk_rdata;
    end else begin
      round_out = mix_cols(sub_shift(state_reg)) ^ rk_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (cmd.blk_load) begin
      counter <= (mode ? {iv_high, iv_low} : counter) + 128'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      state_reg <= mode ? {iv_high, iv_low} : counter;
      text_reg <= {text_high, text_low};
      count_reg <= (byte_count > 5'd16) ? 5'd16 : byte_count;
      round_idx <= '0;
    end else if (cmd.blk_round) begin
      state_reg <= round_out;
      round_idx <= round_idx + 1'b1;
    end
  end

  assign ks = round_out;
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      res[127 - 8 * i -: 8] = (5'(i) < count_reg) ? (get_byte(text_reg, i) ^ get_byte(ks, i))
                                                  : 8'h00;
    end
  end

  // last round result is taken in the same step as its key add
  logic take_res;
  assign take_res = cmd.blk_finish && last_round;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (take_res) begin
      out_full <= 1'b1;
    end else if (out_take) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_res) begin
      out_high <= res[127:64];
      out_low <= res[63:0];
      out_count <= count_reg;
    end
  end

  assign status.out_full = out_full;
endmodule

>>> hw/rtl/aes128_ctr_cipher.sv
// Top level: AES-128 counter-mode cipher with key write port.
// Channels: in (text word with mode, IV and byte count), out (result word),
// cfg (key writes: index 0 key_high, index 1 key_low; other indexes ignored).
// All channels are valid/ready; a word moves when both are high at a clock edge.
// After reset and after every key write the round keys are rebuilt; while
// the block expands them, in and cfg are not ready.
// Between acceptance and the result register each text word gets one
// initial key add plus ten rounds through a single round unit, one per cycle,
// the round key read each cycle from an 11-entry key RAM.
// A new word is accepted only when the block is idle again after the last one.
// The result waits in an output register; while it is not taken a new word
// is not accepted, so a stalled receiver holds the input channel.
// Counter resets to zero; each word sets it to (mode ? IV : ctr) + 1 mod 2^128.
// Reset: rst, synchronous, active high.
module aes128_ctr_cipher (
  input logic clk,
  input logic rst,
  aes_ctr_in_if.sink   in,
  aes_ctr_out_if.source out,
  aes_ctr_cfg_if.sink  cfg
);
  import aes_ctr_pkg::*;

  dp_cmd_t cmd;
  dp_status_t status;
  logic [RkIdxW-1:0] rk_addr;
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic in_fire;
  logic cfg_fire;
  logic key_write;

  assign in_fire = in.valid && in.ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign key_write = cfg_fire && (cfg.index[63:CfgIdxW] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (key_write) begin
      if (cfg.index[CfgIdxW-1:0] == RegKeyHigh) begin
        key_high <= cfg.data;
      end else if (cfg.index[CfgIdxW-1:0] == RegKeyLow) begin
        key_low <= cfg.data;
      end
    end
  end

  aes_ctr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .key_write(key_write),
    .in_fire  (in_fire),
    .status   (status),
    .cmd      (cmd),
    .in_ready (in.ready),
    .cfg_ready(cfg.ready),
    .rk_addr  (rk_addr)
  );

  aes_ctr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rk_addr   (rk_addr),
    .key_high  (key_high),
    .key_low   (key_low),
    .mode      (in.mode),
    .iv_high   (in.iv_high),
    .iv_low    (in.iv_low),
    .text_high (in.text_high),
    .text_low  (in.text_low),
    .byte_count(in.byte_count),
    .out_take  (out.valid && out.ready),
    .status    (status),
    .out_high  (out.out_high),
    .out_low   (out.out_low),
    .out_count (out.out_count)
  );

  assign out.valid = status.out_full;

`ifndef SYNTHESIS
  a_no_accept_while_full: assert property (@(posedge clk) disable iff (rst)
    status.out_full |-> !in.ready) else $error("input accepted while result pending");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.key_start, cmd.key_step, cmd.blk_load, cmd.blk_round, cmd.blk_finish}))
    else $error("conflicting datapath commands");
  a_result_after_rounds: assert property (@(posedge clk) disable iff (rst)
    $rose(status.out_full) |-> $past(cmd.blk_finish)) else $error("result without rounds");
`endif
endmodule
